>>> hdl/fit_policy_block_allocator_macros.svh
// Assertion macros of the fit-policy block allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define FPBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition.
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fpba_pkg.sv
// Types and constants of the fit-policy block allocator.
`default_nettype none

package fpba_pkg;

    localparam int INDEX_W     = 4;
    localparam int AMOUNT_W    = 16;
    localparam int LEFT_W      = 16;
    localparam int COUNT_W     = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_mode_t;

    typedef enum logic [1:0] {
        STAT_LOADED = 2'd0,
        STAT_ALLOC  = 2'd1,
        STAT_WAIT   = 2'd2
    } status_t;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_REQUEST = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIT_MODE    = 1'b0,
        CFG_BLOCK_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        fit_mode_t          fit_mode;
        logic [COUNT_W-1:0] block_count;
    } cfg_t;

    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  chosen_block;
        logic [LEFT_W-1:0]   left_over;
    } res_t;

endpackage

`default_nettype wire

>>> hdl/fpba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/fpba_ctrl.sv
// Sequencer that loads sizes, scans the size table and commits allocations.
`default_nettype none
`include "fit_policy_block_allocator_macros.svh"

module fpba_ctrl #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire fpba_pkg::cfg_t                     cfg,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               in_cmd,
    input  wire logic [fpba_pkg::INDEX_W-1:0]       in_index,
    input  wire logic [fpba_pkg::AMOUNT_W-1:0]      in_amount,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output fpba_pkg::res_t                          res,
    output logic                                    ram_rd_en,
    output logic [$clog2(NUM_BLOCKS)-1:0]           ram_rd_addr,
    input  wire logic [SIZE_BITS-1:0]               ram_rd_data,
    output logic                                    ram_wr_en,
    output logic [$clog2(NUM_BLOCKS)-1:0]           ram_wr_addr,
    output logic [SIZE_BITS-1:0]                    ram_wr_data
);

    import fpba_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
    localparam logic [31:0] SIZE_MAX_W = 32'(SIZE_MAX);

    state_t               state_reg,      state_next;
    logic [CNT_W-1:0]     iss_cnt_reg,    iss_cnt_next;
    logic [CNT_W-1:0]     chk_cnt_reg,    chk_cnt_next;
    logic [IDX_W-1:0]     iss_addr_reg,   iss_addr_next;
    logic                 chk_valid_reg,  chk_valid_next;
    logic [IDX_W-1:0]     chk_addr_reg,   chk_addr_next;
    logic                 found_reg,      found_next;
    logic [IDX_W-1:0]     best_addr_reg,  best_addr_next;
    logic [SIZE_BITS-1:0] best_size_reg,  best_size_next;
    logic [AMOUNT_W-1:0]  amt_reg,        amt_next;
    logic [IDX_W-1:0]     start_addr_reg, start_addr_next;
    logic [IDX_W-1:0]     scan_start_reg, scan_start_next;
    res_t                 res_reg,        res_next;

    logic [CNT_W-1:0] blocks_used;
    logic [IDX_W-1:0] first_addr;
    logic             in_fire;
    logic             load_fire;
    logic             req_fire;
    logic             idx_in_range;
    logic [31:0]      idx_w;
    logic [31:0]      load_amt_w;
    logic [31:0]      load_size_w;
    logic [31:0]      diff_w;
    logic [31:0]      best_addr_w;
    logic             hit;
    logic             better;
    logic             scan_done;
    logic             early_hit;
    logic             update_best;

    always_comb
    begin
        if (32'(cfg.block_count) > NUM_BLOCKS)
        begin
            blocks_used = CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            blocks_used = CNT_W'(cfg.block_count);
        end
    end

    assign first_addr = (cfg.fit_mode == FIT_NEXT && 32'(scan_start_reg) < 32'(blocks_used))
                        ? scan_start_reg : '0;

    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (in_cmd == CMD_LOAD);
    assign req_fire  = in_fire && (in_cmd == CMD_REQUEST);

    assign idx_w        = 32'(in_index);
    assign idx_in_range = idx_w < NUM_BLOCKS;
    assign load_amt_w   = 32'(in_amount);
    assign load_size_w  = (load_amt_w > SIZE_MAX_W) ? SIZE_MAX_W : load_amt_w;
    assign diff_w       = 32'(best_size_reg) - 32'(amt_reg);
    assign best_addr_w  = 32'(best_addr_reg);

    assign hit = chk_valid_reg && (32'(amt_reg) <= 32'(ram_rd_data));

    always_comb
    begin
        unique case (cfg.fit_mode)
            FIT_BEST:  better = ram_rd_data < best_size_reg;
            FIT_WORST: better = ram_rd_data > best_size_reg;
            default:   better = 1'b0;
        endcase
    end

    assign scan_done   = chk_cnt_reg == blocks_used;
    assign early_hit   = hit && (cfg.fit_mode == FIT_FIRST || cfg.fit_mode == FIT_NEXT);
    assign update_best = (state_reg == ST_SCAN) && hit && (!found_reg || better);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_fire)
                begin
                    state_next = ST_RESULT;
                end
                else if (req_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done || early_hit)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = state_reg == ST_IDLE;
        res_valid   = state_reg == ST_RESULT;
        res         = res_reg;
        ram_rd_en   = (state_reg == ST_SCAN) && (iss_cnt_reg < blocks_used);
        ram_rd_addr = iss_addr_reg;
        if (state_reg == ST_COMMIT)
        begin
            ram_wr_en   = found_reg;
            ram_wr_addr = best_addr_reg;
            ram_wr_data = diff_w[SIZE_BITS-1:0];
        end
        else
        begin
            ram_wr_en   = load_fire && idx_in_range;
            ram_wr_addr = idx_w[IDX_W-1:0];
            ram_wr_data = load_size_w[SIZE_BITS-1:0];
        end
    end

    always_comb
    begin
        iss_cnt_next    = iss_cnt_reg;
        chk_cnt_next    = chk_cnt_reg;
        iss_addr_next   = iss_addr_reg;
        chk_valid_next  = ram_rd_en;
        chk_addr_next   = ram_rd_addr;
        found_next      = found_reg;
        best_addr_next  = best_addr_reg;
        best_size_next  = best_size_reg;
        amt_next        = amt_reg;
        start_addr_next = start_addr_reg;
        scan_start_next = scan_start_reg;
        res_next        = res_reg;

        if (req_fire)
        begin
            iss_cnt_next    = '0;
            chk_cnt_next    = '0;
            iss_addr_next   = first_addr;
            start_addr_next = first_addr;
            found_next      = 1'b0;
            amt_next        = in_amount;
        end

        if (load_fire)
        begin
            res_next.status       = STAT_LOADED;
            res_next.chosen_block = in_index;
            res_next.left_over    = idx_in_range ? load_size_w[LEFT_W-1:0] : '0;
        end

        if (ram_rd_en)
        begin
            iss_cnt_next = iss_cnt_reg + 1'b1;
            if (32'(iss_addr_reg) + 32'd1 == 32'(blocks_used))
            begin
                iss_addr_next = '0;
            end
            else
            begin
                iss_addr_next = iss_addr_reg + 1'b1;
            end
        end

        if (state_reg == ST_SCAN && chk_valid_reg)
        begin
            chk_cnt_next = chk_cnt_reg + 1'b1;
        end

        if (update_best)
        begin
            found_next     = 1'b1;
            best_addr_next = chk_addr_reg;
            best_size_next = ram_rd_data;
        end

        if (state_reg == ST_COMMIT)
        begin
            if (found_reg)
            begin
                res_next.status       = STAT_ALLOC;
                res_next.chosen_block = best_addr_w[INDEX_W-1:0];
                res_next.left_over    = diff_w[LEFT_W-1:0];
            end
            else
            begin
                res_next.status       = STAT_WAIT;
                res_next.chosen_block = '0;
                res_next.left_over    = '0;
            end
            if (cfg.fit_mode == FIT_NEXT)
            begin
                scan_start_next = found_reg ? best_addr_reg : start_addr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iss_cnt_reg    <= '0;
            chk_cnt_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            scan_start_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_cnt_reg    <= iss_cnt_next;
            chk_cnt_reg    <= chk_cnt_next;
            chk_valid_reg  <= chk_valid_next;
            found_reg      <= found_next;
            scan_start_reg <= scan_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_addr_reg   <= iss_addr_next;
        chk_addr_reg   <= chk_addr_next;
        best_addr_reg  <= best_addr_next;
        best_size_reg  <= best_size_next;
        amt_reg        <= amt_next;
        start_addr_reg <= start_addr_next;
        res_reg        <= res_next;
    end

    `FPBA_ASSERT_SAME(a_no_write_in_scan, clk, rst_n, state_reg == ST_SCAN, !ram_wr_en, "table written during scan")
    `FPBA_ASSERT_SAME(a_checks_follow_reads, clk, rst_n, state_reg == ST_SCAN, chk_cnt_reg <= iss_cnt_reg, "more entries checked than read")
    `FPBA_ASSERT_NEXT(a_commit_to_result, clk, rst_n, state_reg == ST_COMMIT, state_reg == ST_RESULT, "commit not followed by result")
    `FPBA_ASSERT_SAME(a_wait_is_empty, clk, rst_n, res_valid && res_reg.status == STAT_WAIT, res_reg.chosen_block == '0 && res_reg.left_over == '0, "wait result carries data")

endmodule

`default_nettype wire

>>> hdl/fit_policy_block_allocator.sv
// Top level of the fit-policy block allocator.
//
// Input words on s_axis: tuser is the command (load or request), tdata holds
// the block index and the amount. Each input word gives one output word on
// m_axis: tuser is the status, tdata holds the chosen block and its left-over
// size. Configuration writes on cfg_* select the fit mode and the block count;
// cfg_ready is always high.
// A load's result is registered in the controller and then moves to the output
// register. A request reads the size table one entry per cycle through the RAM
// read port and reaches the output register through the scan, commit and result
// states; first and next fit stop the scan at the first block that fits. One
// word is in work at a time: the next word is accepted once the result has
// moved to the output register, which holds it while m_axis_tready is low.
// Reset clears the control state, sets first fit, 16 blocks and the next-fit
// pointer to zero; block sizes are undefined until loaded.
`default_nettype none

module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fpba_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [23:0]                         s_axis_tdata,  // block_index, amount
    input  wire logic                                s_axis_tuser,  // cmd
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [23:0]                              m_axis_tdata,  // chosen_block, left_over
    output logic [1:0]                               m_axis_tuser   // status
);

    import fpba_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    cfg_t       cfg_reg, cfg_next;
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg, out_res_next;
    res_t       res;
    logic       res_valid;
    logic       res_ready;

    logic                 ram_rd_en;
    logic [IDX_W-1:0]     ram_rd_addr;
    logic [SIZE_BITS-1:0] ram_rd_data;
    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic [SIZE_BITS-1:0] ram_wr_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FIT_MODE:    cfg_next.fit_mode    = fit_mode_t'(cfg_data[1:0]);
                CFG_BLOCK_COUNT: cfg_next.block_count = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fit_mode    <= FIT_FIRST;
            cfg_reg.block_count <= BLOCK_COUNT_RESET;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {4'b0, out_res_reg.left_over, out_res_reg.chosen_block};

    fpba_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser),
        .in_index    (s_axis_tdata[3:0]),
        .in_amount   (s_axis_tdata[19:4]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench of the fit-policy block allocator: directed and random word streams.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import fpba_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [3:0]  idx;
        logic [15:0] amt;
    } alloc_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    alloc_word_t word_queue[$];
    res_t        expected_grants[$];

    logic [15:0] blk_size[16];
    logic [3:0]  nf_ptr;
    fit_mode_t   cur_mode;
    logic [4:0]  blk_cnt;

    int fail_count = 0;
    int gap_pct = 0;
    int send_gap = 0;
    int sink_gap = 0;

    fit_policy_block_allocator #(
        .NUM_BLOCKS(16),
        .SIZE_BITS (16)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic res_t predict_grant(cmd_t cmd, logic [3:0] idx, logic [15:0] amt);
        res_t r;
        int   n;
        int   p;
        int   pick;
        bit   found;
        r = '0;
        if (cmd == CMD_LOAD)
        begin
            blk_size[idx] = amt;
            r.status = STAT_LOADED;
            r.chosen_block = idx;
            r.left_over = amt;
            return r;
        end
        n = (blk_cnt > 16) ? 16 : int'(blk_cnt);
        pick = n;
        if (cur_mode == FIT_NEXT)
        begin
            p = (int'(nf_ptr) < n) ? int'(nf_ptr) : 0;
            found = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (!found)
                begin
                    if (amt <= blk_size[p])
                    begin
                        found = 1'b1;
                        pick = p;
                    end
                    else
                        p = (p + 1 == n) ? 0 : p + 1;
                end
            end
            nf_ptr = 4'(p);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (amt <= blk_size[i])
                begin
                    if (pick == n)
                        pick = i;
                    else if (cur_mode == FIT_BEST && blk_size[i] < blk_size[pick])
                        pick = i;
                    else if (cur_mode == FIT_WORST && blk_size[i] > blk_size[pick])
                        pick = i;
                end
            end
        end
        if (pick < n)
        begin
            blk_size[pick] = blk_size[pick] - amt;
            r.status = STAT_ALLOC;
            r.chosen_block = 4'(pick);
            r.left_over = blk_size[pick];
        end
        else
            r.status = STAT_WAIT;
        return r;
    endfunction

    // driver: advance to the next word once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        alloc_word_t w;
        logic        nv;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_grants.push_back(predict_grant(cmd_t'(s_axis_tuser),
                    s_axis_tdata[3:0], s_axis_tdata[19:4]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                nv = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (gap_pct > 0 && $urandom_range(99) < gap_pct)
                    send_gap = $urandom_range(1, 11) - 1;
                else if (word_queue.size() > 0)
                begin
                    w = word_queue.pop_front();
                    nv = 1'b1;
                    s_axis_tuser <= w.cmd;
                    s_axis_tdata <= {4'b0, w.amt, w.idx};
                end
                s_axis_tvalid <= nv;
            end
        end
    end

    // monitor: check each word against the oldest expected grant
    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        res_t act_r;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                act_r.status = status_t'(m_axis_tuser);
                act_r.chosen_block = m_axis_tdata[3:0];
                act_r.left_over = m_axis_tdata[19:4];
                if (expected_grants.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: status %0d block %0d left %0d",
                            act_r.status, act_r.chosen_block, act_r.left_over);
                end
                else
                begin
                    exp_r = expected_grants.pop_front();
                    if (act_r.status != exp_r.status
                        || act_r.chosen_block != exp_r.chosen_block
                        || act_r.left_over != exp_r.left_over)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected status %0d block %0d left %0d, %s %0d %0d %0d",
                                exp_r.status, exp_r.chosen_block, exp_r.left_over,
                                "got", act_r.status, act_r.chosen_block, act_r.left_over);
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (gap_pct > 0 && $urandom_range(99) < gap_pct)
            begin
                sink_gap = $urandom_range(1, 11) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FIT_MODE)
            cur_mode = fit_mode_t'(val[1:0]);
        else
            blk_cnt = val;
    endtask

    task automatic set_cfg(fit_mode_t mode, logic [4:0] count);
        write_reg(CFG_FIT_MODE, {3'($urandom_range(7)), mode});
        write_reg(CFG_BLOCK_COUNT, count);
        @(negedge clk);
    endtask

    task automatic push_word(cmd_t cmd, logic [3:0] idx, logic [15:0] amt);
        alloc_word_t w;
        w.cmd = cmd;
        w.idx = idx;
        w.amt = amt;
        word_queue.push_back(w);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (word_queue.size() != 0 || s_axis_tvalid || expected_grants.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_phase(fit_mode_t mode, logic [4:0] count, int n_words);
        logic [15:0] amt;
        set_cfg(mode, count);
        for (int i = 0; i < n_words; i++)
        begin
            if ($urandom_range(99) < 30)
            begin
                amt = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
                push_word(CMD_LOAD, 4'($urandom_range(15)), amt);
            end
            else
            begin
                case ($urandom_range(9))
                    0, 1:    amt = 16'($urandom);
                    2, 3, 4: amt = 16'($urandom_range(0, 4095));
                    default: amt = 16'($urandom_range(0, 255));
                endcase
                push_word(CMD_REQUEST, 4'($urandom_range(15)), amt);
            end
        end
        wait_idle();
    endtask

    initial
    begin
        logic [4:0] count;
        int         n_words;
        nf_ptr = '0;
        cur_mode = FIT_FIRST;
        blk_cnt = BLOCK_COUNT_RESET;
        for (int i = 0; i < 16; i++)
            blk_size[i] = '0;
        @(posedge rst_n);
        repeat (2) @(negedge clk);

        set_cfg(FIT_FIRST, 5'd16);
        for (int i = 0; i < 16; i++)
            push_word(CMD_LOAD, 4'(i), (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF
                : 16'(40 + (i % 5) * 25));
        push_word(CMD_REQUEST, 4'd15, 16'd0);
        push_word(CMD_REQUEST, 4'd0, 16'hFFFF);
        push_word(CMD_REQUEST, 4'd9, 16'd60);
        wait_idle();

        set_cfg(FIT_NEXT, 5'd5);
        push_word(CMD_REQUEST, 4'd0, 16'd10);
        push_word(CMD_REQUEST, 4'd0, 16'd10);
        push_word(CMD_REQUEST, 4'd0, 16'd10);
        push_word(CMD_REQUEST, 4'd0, 16'd50000);
        wait_idle();

        set_cfg(FIT_NEXT, 5'd3);
        push_word(CMD_REQUEST, 4'd0, 16'd5);
        push_word(CMD_LOAD, 4'd12, 16'd7);
        wait_idle();

        set_cfg(FIT_BEST, 5'd16);
        push_word(CMD_REQUEST, 4'd0, 16'd7);
        wait_idle();

        set_cfg(FIT_WORST, 5'd16);
        push_word(CMD_REQUEST, 4'd0, 16'd1);
        wait_idle();

        set_cfg(FIT_FIRST, 5'd0);
        push_word(CMD_REQUEST, 4'd0, 16'd1);
        wait_idle();

        set_cfg(FIT_BEST, 5'd31);
        push_word(CMD_REQUEST, 4'd0, 16'd2);
        wait_idle();

        for (int ph = 0; ph < 16; ph++)
        begin
            if (ph >= 13)
                gap_pct = 0;
            else
                case ($urandom_range(2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 45;
                endcase
            n_words = 100;
            case (ph)
                1:       count = 5'd1;
                2, 7:    count = 5'd16;
                5:
                begin
                    count = 5'd0;
                    n_words = 20;
                end
                9:       count = 5'($urandom_range(17, 31));
                default: count = 5'($urandom_range(1, 16));
            endcase
            random_phase(fit_mode_t'(ph % 4), count, n_words);
        end

        repeat (30) @(posedge clk);
        if (fail_count == 0 && expected_grants.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> fit_policy_block_allocator.f
+incdir+hdl
hdl/fpba_pkg.sv
hdl/fpba_ram.sv
hdl/fpba_ctrl.sv
hdl/fit_policy_block_allocator.sv
tb/tb_top.sv
